### src/uepa_pkg.sv
// ----------------------------------------------------------------------------
// uepa_pkg - shared types and constants for the endpoint slot allocator
// Request/result layouts, operation and status codes, controller states and
// the receive count word encoder.
// ----------------------------------------------------------------------------
package uepa_pkg;

  // Field widths
  localparam int OP_W   = 3;
  localparam int EP_W   = 4;
  localparam int SIZE_W = 10;
  localparam int ST_W   = 2;
  localparam int OSLOT_W = 3;
  localparam int OADDR_W = 9;
  localparam int CW_W   = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_RESTART = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_IN  = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_OUT = 3'd2;
  localparam logic [OP_W-1:0] OP_DBL_IN  = 3'd3;
  localparam logic [OP_W-1:0] OP_DBL_OUT = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_SLOT = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_MEM  = 2'd2;

  // Descriptor table bytes per slot
  localparam int DESC_BYTES = 8;

  // Request payload, last field in the low bits
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [EP_W-1:0]   endpoint;
    logic [OP_W-1:0]   operation;
  } req_t;

  // Result payload, last field in the low bits
  typedef struct packed {
    logic              out_double;
    logic              in_double;
    logic [SIZE_W-1:0] out_size;
    logic [SIZE_W-1:0] in_size;
    logic              receive_ready;
    logic [CW_W-1:0]   count_word;
    logic [OADDR_W-1:0] paired_address;
    logic [OADDR_W-1:0] buffer_address;
    logic [OSLOT_W-1:0] slot;
    logic [ST_W-1:0]   status;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } ctl_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC
  } state_t;

  // Receive count word: 2-byte blocks up to 62 bytes, else 32-byte blocks
  function automatic logic [CW_W-1:0] rx_count_code(input logic [SIZE_W-1:0] n);
    logic [4:0] blocks;
    logic       big;
    begin
      big = (n > 10'd62);
      if (!big) begin
        blocks = n[5:1] + {4'd0, n[0]};
      end else begin
        blocks = n[9:5] - {4'd0, (n[4:0] == 5'd0)};
      end
      rx_count_code = {big, blocks, 10'd0};
    end
  endfunction

endpackage

### src/usb_endpoint_slot_and_buffer_allocator.sv
// ----------------------------------------------------------------------------
// usb_endpoint_slot_and_buffer_allocator - endpoint slot and buffer allocator
// Maps USB endpoints to hardware slots and carves packet buffers downward
// from the top of packet memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ stream (operation, endpoint, size); each one
//   yields exactly one result on the out_ stream. There is no config port.
//   A request is taken in the idle cycle, the slot table is matched in the
//   next cycle and the execute cycle updates the table, the pointer and the
//   result register, so out_tvalid rises once the execute cycle commits.
//   The lookup/execute sequencer handles one request at a time and takes
//   no new request until the last one has left its execute cycle.
//   The result register lets the next request enter while a result waits;
//   if the receiver stalls, that request holds in its execute cycle and
//   in_tready stays low until the waiting result is taken.
//   Reset clears every slot mapping, size, flag and address and returns the
//   allocation pointer to BUFFER_TOP; no clearing pass is needed.
// ----------------------------------------------------------------------------
module usb_endpoint_slot_and_buffer_allocator #(
  parameter int SLOTS      = 8,
  parameter int BUFFER_TOP = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // operation[2:0], endpoint[6:3], size[16:7]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // status[1:0], slot[4:2], buffer_address[13:5],
                                  // paired_address[22:14], count_word[38:23],
                                  // receive_ready[39], in_size[49:40],
                                  // out_size[59:50], in_double[60], out_double[61]
);
  import uepa_pkg::*;

  ctl_cmd_t cmd;
  req_t     req;
  res_t     res;

  assign req = req_t'(in_tdata[$bits(req_t)-1:0]);

  uepa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  uepa_dp #(
    .SLOTS      (SLOTS),
    .BUFFER_TOP (BUFFER_TOP)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .req   (req),
    .res   (res)
  );

  assign out_tdata = {{(64 - $bits(res_t)){1'b0}}, res};

endmodule

### src/uepa_ctrl.sv
// ----------------------------------------------------------------------------
// uepa_ctrl - request sequencer for the endpoint slot allocator
// Takes one request, steps it through lookup and execute, and owns the
// result valid flag so a new request can start while a result waits.
// ----------------------------------------------------------------------------
module uepa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output uepa_pkg::ctl_cmd_t cmd
);
  import uepa_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: state_nxt = S_EXEC;
      S_EXEC: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_tready   = 1'b0;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_LOOKUP: cmd.lookup = 1'b1;
      S_EXEC:   cmd.commit = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // Result valid: set on commit, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("result not presented after commit");

  a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result valid without commit");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_tready ##1 !in_tready)
    else $error("request accepted while another is in work");

endmodule

### src/uepa_dp.sv
// ----------------------------------------------------------------------------
// uepa_dp - slot table, allocation pointer and result register
// Parallel endpoint match with lowest-index priority, then the size check,
// pointer update, table write and result build in the execute cycle.
// ----------------------------------------------------------------------------
module uepa_dp #(
  parameter int SLOTS      = 8,
  parameter int BUFFER_TOP = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  uepa_pkg::ctl_cmd_t cmd,
  input  uepa_pkg::req_t     req,
  output uepa_pkg::res_t     res
);
  import uepa_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = $clog2(BUFFER_TOP + 1);
  localparam int CW = ((PW > SIZE_W + 1) ? PW : SIZE_W + 1) + 1;

  // Slot table
  logic              valid_r  [SLOTS];
  logic [EP_W-1:0]   ep_r     [SLOTS];
  logic [SIZE_W-1:0] isz_r    [SLOTS];
  logic [SIZE_W-1:0] osz_r    [SLOTS];
  logic              idbl_r   [SLOTS];
  logic              odbl_r   [SLOTS];
  logic [PW-1:0]     tx_r     [SLOTS];
  logic [PW-1:0]     rx_r     [SLOTS];
  logic [PW-1:0]     ptr_r;

  // Request and lookup registers
  req_t          req_r;
  logic [SW-1:0] slot_r;
  logic          found_r;
  logic          claim_r;
  res_t          res_r;

  logic          size_op;
  logic [SLOTS-1:0] hit_vec, free_vec;
  logic [SW-1:0] hit_idx, free_idx;

  assign size_op = (req_r.operation == OP_SET_IN) || (req_r.operation == OP_SET_OUT);

  // Endpoint match and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i]  = valid_r[i] && (ep_r[i] == req_r.endpoint);
      free_vec[i] = !valid_r[i];
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i])  hit_idx  = SW'(i);
      if (free_vec[i]) free_idx = SW'(i);
    end
  end

  // Execute: size check, new pointer and result
  logic [SIZE_W-1:0] n;
  logic [CW-1:0]     need;
  logic              too_low;
  logic [CW-1:0]     dec;
  logic [PW-1:0]     ptr_new;
  logic [PW-1:0]     buf_addr;
  logic              op_known;
  logic              dbl_op;
  res_t              res_nxt;
  logic [SIZE_W-1:0] isz_cur, osz_cur;
  logic              idbl_cur, odbl_cur;

  assign dbl_op   = (req_r.operation == OP_DBL_IN) || (req_r.operation == OP_DBL_OUT);
  assign op_known = size_op || dbl_op || (req_r.operation == OP_QUERY);

  always_comb begin
    case (req_r.operation)
      OP_DBL_IN:  n = isz_r[slot_r];
      OP_DBL_OUT: n = osz_r[slot_r];
      default:    n = req_r.size;
    endcase
    need    = CW'(n) + CW'(SLOTS * DESC_BYTES);
    too_low = CW'(ptr_r) < need;
    dec     = size_op ? (CW'(n) + CW'(n[0])) : CW'(n);
    ptr_new = PW'(CW'(ptr_r) - dec);
    buf_addr = {ptr_new[PW-1:1], 1'b0};

    isz_cur  = isz_r[slot_r];
    osz_cur  = osz_r[slot_r];
    idbl_cur = idbl_r[slot_r];
    odbl_cur = odbl_r[slot_r];

    res_nxt = '0;
    if (op_known && !found_r) begin
      res_nxt.status = ST_NO_SLOT;
    end else if (op_known) begin
      res_nxt.slot = OSLOT_W'(slot_r);
      if ((size_op || dbl_op) && too_low) begin
        res_nxt.status = ST_NO_MEM;
      end else begin
        res_nxt.status = ST_OK;
        if (size_op || dbl_op) res_nxt.buffer_address = OADDR_W'(buf_addr);
        case (req_r.operation)
          OP_SET_IN: isz_cur = req_r.size;
          OP_SET_OUT: begin
            osz_cur = req_r.size;
            res_nxt.count_word    = rx_count_code(req_r.size);
            res_nxt.receive_ready = (req_r.endpoint == '0);
          end
          OP_DBL_IN: begin
            idbl_cur = 1'b1;
            res_nxt.paired_address = OADDR_W'(tx_r[slot_r]);
          end
          OP_DBL_OUT: begin
            odbl_cur = 1'b1;
            res_nxt.paired_address = OADDR_W'(rx_r[slot_r]);
            res_nxt.count_word     = rx_count_code(n);
            res_nxt.receive_ready  = 1'b1;
          end
          default: ;
        endcase
      end
      res_nxt.in_size    = isz_cur;
      res_nxt.out_size   = osz_cur;
      res_nxt.in_double  = idbl_cur;
      res_nxt.out_double = odbl_cur;
    end
  end

  // Request capture, lookup and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= req;
    if (cmd.lookup) begin
      slot_r  <= (|hit_vec) ? hit_idx : free_idx;
      found_r <= (|hit_vec) || (size_op && (|free_vec));
      claim_r <= !(|hit_vec) && size_op && (|free_vec);
    end
    if (cmd.commit) res_r <= res_nxt;
  end

  // Slot table and pointer update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= PW'(BUFFER_TOP);
      for (int i = 0; i < SLOTS; i++) begin
        valid_r[i] <= 1'b0;
        ep_r[i]    <= '0;
        isz_r[i]   <= '0;
        osz_r[i]   <= '0;
        idbl_r[i]  <= 1'b0;
        odbl_r[i]  <= 1'b0;
        tx_r[i]    <= '0;
        rx_r[i]    <= '0;
      end
    end else if (cmd.commit) begin
      if (req_r.operation == OP_RESTART) ptr_r <= PW'(BUFFER_TOP);
      if (claim_r) begin
        valid_r[slot_r] <= 1'b1;
        ep_r[slot_r]    <= req_r.endpoint;
      end
      if (found_r && (size_op || dbl_op) && !too_low) begin
        ptr_r <= ptr_new;
        case (req_r.operation)
          OP_SET_IN: begin
            isz_r[slot_r] <= req_r.size;
            tx_r[slot_r]  <= buf_addr;
          end
          OP_SET_OUT: begin
            osz_r[slot_r] <= req_r.size;
            rx_r[slot_r]  <= buf_addr;
          end
          OP_DBL_IN: begin
            rx_r[slot_r]   <= buf_addr;
            idbl_r[slot_r] <= 1'b1;
          end
          OP_DBL_OUT: begin
            tx_r[slot_r]   <= rx_r[slot_r];
            rx_r[slot_r]   <= buf_addr;
            odbl_r[slot_r] <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign res = res_r;

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PW'(BUFFER_TOP))
    else $error("allocation pointer above buffer top");

  a_slot_kept: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(valid_r[slot_r]) && $stable(slot_r) |-> valid_r[slot_r])
    else $error("mapped slot released");

  a_claim_size_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && claim_r |-> size_op && found_r)
    else $error("slot claimed by a non-size request");

endmodule
